// File: design/fir11_pkg.sv
// ----------------------------------------------------------------------------
// fir11_pkg
// Widths and defaults used by the FIR filter.
// ----------------------------------------------------------------------------
package fir11_pkg;

    localparam int SAMPLE_W     = 16;  // audio sample width
    localparam int COEF_W       = 16;  // Q1.15 coefficient width
    localparam int FRAC_BITS    = 15;  // fractional bits of a coefficient
    localparam int CFG_W        = 64;  // configuration word width
    localparam int CFG_IDX_W    = 2;   // configuration register index width
    localparam int COEF_PER_CFG = CFG_W / COEF_W;
    localparam int TAPS_DEFAULT = 11;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

endpackage

// File: design/fir11_ram.sv
// ----------------------------------------------------------------------------
// fir11_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fir11_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fir_filter_11_tap.sv
// ----------------------------------------------------------------------------
// fir_filter_11_tap
// Direct-form FIR filter over signed 16-bit samples with Q1.15 coefficients.
// ----------------------------------------------------------------------------
// Each item is one sample x[n]; the filter returns one item
// y = sat16(trunc0(sum h[k]*x[n-k]) >> 15). Past samples live in a circular
// buffer in a small RAM of TAPS-1 entries, and one shared 16x16 multiplier
// takes one tap per cycle. Steps: a multiply step per tap, tap 0 on the new
// sample and each later tap on one RAM read; a drain step that folds the
// last product into the accumulator; a final step that rounds, saturates,
// loads the result and writes the sample back. A new item is taken once idle
// again, while the result may still wait in the output register; if still
// stalled, it holds the next item in its final step. The user must write
// coefficients through the configuration port only while idle; the block
// does not enforce it. Delay-line entries not yet written since reset read
// as zero, tracked by a fill count, so no clearing pass is needed.
module fir_filter_11_tap #(
    parameter int TAPS = fir11_pkg::TAPS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [fir11_pkg::SAMPLE_W-1:0] i_in_sample,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [fir11_pkg::SAMPLE_W-1:0] o_out_sample,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fir11_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fir11_pkg::CFG_W-1:0]     i_cfg_data
);

    import fir11_pkg::*;

    localparam int DLEN       = TAPS - 1;
    localparam int AW         = (DLEN > 1) ? $clog2(DLEN) : 1;
    localparam int TW         = $clog2(TAPS);
    localparam int FW         = $clog2(DLEN + 1);
    localparam int CW         = (TW > FW) ? TW : FW;
    localparam int COEF_WORDS = (TAPS + COEF_PER_CFG - 1) / COEF_PER_CFG;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + $clog2(TAPS);

    localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO  = -ACC_W'(1 << (SAMPLE_W - 1));
    localparam logic signed [ACC_W-1:0] RND_NEG = ACC_W'((1 << FRAC_BITS) - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state                    r_state;
    logic [CFG_W-1:0]          r_coef [COEF_WORDS];
    t_sample                   r_x;
    logic [TW-1:0]             r_tap;
    logic [AW-1:0]             r_rd;
    logic [AW-1:0]             r_wp;
    logic [FW-1:0]             r_fill;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_pvld;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_ovld;
    t_sample                   r_y;

    logic [AW-1:0]             n_rd;
    t_sample                   n_y;
    t_coef                     c_tap [TAPS];
    t_coef                     cur_coef;
    t_sample                   cur_opd;
    logic [SAMPLE_W-1:0]       ram_rdata;
    logic                      ram_we;
    logic                      in_acc;
    logic                      out_free;
    logic signed [ACC_W-1:0]   acc_adj;
    logic signed [ACC_W-1:0]   acc_shr;

    // Tap k sits in a fixed slice of the coefficient words.
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        assign c_tap[k] = r_coef[k / COEF_PER_CFG][(k % COEF_PER_CFG) * COEF_W +: COEF_W];
    end

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DLEN - 1) : p - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DLEN - 1)) ? '0 : p + AW'(1);
    endfunction

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_ovld || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovld;
    assign o_out_sample = r_y;

    // Tap 0 uses the new sample; later taps use the RAM word read for them
    // in the previous cycle, or zero while that entry has never been written.
    assign cur_coef = c_tap[r_tap];
    always_comb begin
        if (r_tap == '0) begin
            cur_opd = r_x;
        end else if (CW'(r_tap) <= CW'(r_fill)) begin
            cur_opd = t_sample'(ram_rdata);
        end else begin
            cur_opd = '0;
        end
    end

    // The read address for delay entry j is wp-1-j. The first read is issued
    // at acceptance and repeated during tap 0 so its data lands on tap 1.
    always_comb begin
        if (r_state == S_IDLE) begin
            n_rd = ptr_dec(r_wp);
        end else if (r_state == S_RUN && r_tap != '0) begin
            n_rd = ptr_dec(r_rd);
        end else begin
            n_rd = r_rd;
        end
    end

    // Shift right with truncation toward zero, then saturate.
    assign acc_adj = r_acc + (r_acc[ACC_W-1] ? RND_NEG : '0);
    assign acc_shr = acc_adj >>> FRAC_BITS;
    always_comb begin
        if (acc_shr > SAT_HI) begin
            n_y = t_sample'(SAT_HI);
        end else if (acc_shr < SAT_LO) begin
            n_y = t_sample'(SAT_LO);
        end else begin
            n_y = t_sample'(acc_shr);
        end
    end

    // The write-back happens only in the final step, after every read of the
    // item, and the next item's reads start later, so accesses never overlap.
    assign ram_we = (r_state == S_FIN) && out_free;

    fir11_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DLEN),
        .AW    (AW)
    ) u_delay (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_x),
        .i_raddr (n_rd),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_ovld  <= 1'b0;
            r_pvld  <= 1'b0;
            r_tap   <= '0;
            r_rd    <= '0;
            for (int w = 0; w < COEF_WORDS; w++) begin
                r_coef[w] <= '0;
            end
        end else begin
            r_rd <= n_rd;

            if (i_cfg_valid && o_cfg_ready) begin
                for (int w = 0; w < COEF_WORDS; w++) begin
                    if (i_cfg_index == CFG_IDX_W'(w)) begin
                        r_coef[w] <= i_cfg_data;
                    end
                end
            end

            // In the final step a taken result is replaced by the new one there.
            if (r_ovld && !i_out_stall && r_state != S_FIN) begin
                r_ovld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x     <= i_in_sample;
                        r_tap   <= '0;
                        r_acc   <= '0;
                        r_pvld  <= 1'b0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_prod <= cur_coef * cur_opd;
                    r_pvld <= 1'b1;
                    if (r_pvld) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    if (r_tap == TW'(TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_tap <= r_tap + TW'(1);
                    end
                end
                S_DRAIN: begin
                    r_acc   <= r_acc + ACC_W'(r_prod);
                    r_pvld  <= 1'b0;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_y     <= n_y;
                        r_ovld  <= 1'b1;
                        r_wp    <= ptr_inc(r_wp);
                        if (r_fill != FW'(DLEN)) begin
                            r_fill <= r_fill + FW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DLEN))
        else $error("delay-line fill count exceeds its depth");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= AW'(DLEN - 1))
        else $error("write pointer outside the delay line");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("filter took an item without going busy");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result appeared outside the final step");

    a_drain_has_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_pvld)
        else $error("last product missing at drain");
`endif

endmodule
